// ----- design/vbd_pkg.sv -----
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types, widths and constant tables for the volume box downsampler.
// ----------------------------------------------------------------------------
package vbd_pkg;

    localparam int VOXEL_W    = 16;
    localparam int COORD_W    = 6;
    localparam int OFS_W      = 3;
    localparam int FACTOR_W   = 4;
    localparam int SIZE_W     = 7;
    localparam int SUM_W      = 26;
    localparam int MAG_W      = 25;
    localparam int RECIP_W    = 26;
    localparam int SHIFT_W    = 6;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int IDX_W      = 2 * COORD_W;
    localparam int PLANE_CELLS = 1 << IDX_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd2;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd64;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 4'd8;
    localparam logic [SIZE_W-1:0]   SIZE_MAX     = 7'd64;

    typedef enum logic [1:0] {
        REG_FACTOR = 2'd0,
        REG_SIZE_X = 2'd1,
        REG_SIZE_Y = 2'd2,
        REG_SIZE_Z = 2'd3
    } reg_idx_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [SIZE_W-1:0]   size_x;
        logic [SIZE_W-1:0]   size_y;
        logic [SIZE_W-1:0]   size_z;
    } cfg_t;

    // one classified voxel on its way to the accumulator
    typedef struct packed {
        logic signed [VOXEL_W-1:0] voxel;
        logic [IDX_W-1:0]          idx;
        logic                      first;
        logic                      emit;
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
        logic [COORD_W-1:0]        cz;
        logic                      done;
    } entry_t;

    typedef struct packed {
        logic [RECIP_W-1:0] mult;
        logic [SHIFT_W-1:0] shift;
    } recip_t;

    // ceil(2^(25+L)/f^3) with L = ceil(log2(f^3)); exact for magnitudes below 2^25
    function automatic recip_t recip_of(input logic [FACTOR_W-1:0] f);
        recip_t r;
        r.mult  = 26'd33554432;
        r.shift = 6'd25;
        case (f)
            4'd2:    begin r.mult = 26'd33554432; r.shift = 6'd28; end
            4'd3:    begin r.mult = 26'd39768216; r.shift = 6'd30; end
            4'd4:    begin r.mult = 26'd33554432; r.shift = 6'd31; end
            4'd5:    begin r.mult = 26'd34359739; r.shift = 6'd32; end
            4'd6:    begin r.mult = 26'd39768216; r.shift = 6'd33; end
            4'd7:    begin r.mult = 26'd50087083; r.shift = 6'd34; end
            4'd8:    begin r.mult = 26'd33554432; r.shift = 6'd34; end
            default: begin r.mult = 26'd33554432; r.shift = 6'd25; end
        endcase
        return r;
    endfunction

endpackage

// ----- design/volume_box_downsampler_core.sv -----
// ----------------------------------------------------------------------------
// volume_box_downsampler_core
// 3D average pooling of a streamed volume by a cubic window.
// ----------------------------------------------------------------------------
// Usage:
//   Voxels enter on in_valid/in_ready in raster order, z fastest, then y,
//   then x. Every voxel that lies inside a whole window is added to the
//   running sum of its cell; on the last voxel of a cell one beat leaves on
//   out_valid/out_ready with the mean (sum / factor^3, truncated toward
//   zero), the cell coordinates and volume_done on the final cell.
//   Voxels past the last whole window on any axis are dropped.
//   Throughput: one voxel per cycle unless out_ready stalls the output,
//   set by the single read and write port of the plane sum memory, with a
//   bypass for back-to-back hits on a cell. An accepted voxel passes queue
//   pop and memory read, accumulate, reciprocal multiply, output register.
//   A four-entry queue sits between classification and accumulation; when
//   the receiver stalls the back pipe holds and in_ready falls once the
//   queue fills, never losing a beat.
//   Reset: factor 2, sizes 64, position zero; the plane sums need no clear
//   since the first voxel of each cell overwrites its sum.
//   Any register write over the APB port restarts the volume at the origin.
// ----------------------------------------------------------------------------
module volume_box_downsampler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vbd_pkg::PADDR_W-1:0]         paddr,
    input  logic [vbd_pkg::PDATA_W-1:0]         pwdata,
    output logic [vbd_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vbd_pkg::VOXEL_W-1:0]  voxel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vbd_pkg::VOXEL_W-1:0]  mean_value,
    output logic [vbd_pkg::COORD_W-1:0]         cell_x,
    output logic [vbd_pkg::COORD_W-1:0]         cell_y,
    output logic [vbd_pkg::COORD_W-1:0]         cell_z,
    output logic                                volume_done
);

    localparam int SW = vbd_pkg::SIZE_W;

    logic [vbd_pkg::FACTOR_W-1:0] factor_reg;
    logic [SW-1:0]                size_x_reg, size_y_reg, size_z_reg;
    logic                         wr_acc;
    vbd_pkg::reg_idx_t            reg_sel;
    vbd_pkg::cfg_t                cfg;

    logic                         accept;
    logic                         push;
    vbd_pkg::entry_t              push_data;
    logic                         pop;
    vbd_pkg::entry_t              pop_data;
    logic                         q_full;
    logic                         q_empty;

    assign pready  = 1'b1;
    assign wr_acc  = psel && penable && pwrite && pready;
    assign reg_sel = vbd_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= vbd_pkg::FACTOR_RESET;
            size_x_reg <= vbd_pkg::SIZE_RESET;
            size_y_reg <= vbd_pkg::SIZE_RESET;
            size_z_reg <= vbd_pkg::SIZE_RESET;
        end
        else if (wr_acc)
        begin
            unique case (reg_sel)
                vbd_pkg::REG_FACTOR: factor_reg <= pwdata[vbd_pkg::FACTOR_W-1:0];
                vbd_pkg::REG_SIZE_X: size_x_reg <= pwdata[SW-1:0];
                vbd_pkg::REG_SIZE_Y: size_y_reg <= pwdata[SW-1:0];
                vbd_pkg::REG_SIZE_Z: size_z_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            vbd_pkg::REG_FACTOR: prdata = vbd_pkg::PDATA_W'(factor_reg);
            vbd_pkg::REG_SIZE_X: prdata = vbd_pkg::PDATA_W'(size_x_reg);
            vbd_pkg::REG_SIZE_Y: prdata = vbd_pkg::PDATA_W'(size_y_reg);
            vbd_pkg::REG_SIZE_Z: prdata = vbd_pkg::PDATA_W'(size_z_reg);
            default:             prdata = '0;
        endcase
    end

    // clamp register values to their working ranges
    always_comb
    begin
        if (factor_reg == '0)
        begin
            cfg.factor = vbd_pkg::FACTOR_W'(1);
        end
        else if (factor_reg > vbd_pkg::FACTOR_MAX)
        begin
            cfg.factor = vbd_pkg::FACTOR_MAX;
        end
        else
        begin
            cfg.factor = factor_reg;
        end
        cfg.size_x = (size_x_reg == '0) ? SW'(1) :
                     (size_x_reg > vbd_pkg::SIZE_MAX) ? vbd_pkg::SIZE_MAX : size_x_reg;
        cfg.size_y = (size_y_reg == '0) ? SW'(1) :
                     (size_y_reg > vbd_pkg::SIZE_MAX) ? vbd_pkg::SIZE_MAX : size_y_reg;
        cfg.size_z = (size_z_reg == '0) ? SW'(1) :
                     (size_z_reg > vbd_pkg::SIZE_MAX) ? vbd_pkg::SIZE_MAX : size_z_reg;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    vbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (wr_acc),
        .accept    (accept),
        .push      (push),
        .push_data (push_data),
        .voxel     (voxel)
    );

    vbd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    vbd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean_value  (mean_value),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .volume_done (volume_done)
    );

endmodule

// ----- design/vbd_fifo.sv -----
// ----------------------------------------------------------------------------
// vbd_fifo
// Short queue of classified voxels between the front and the back.
// ----------------------------------------------------------------------------
module vbd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vbd_pkg::entry_t push_data,
    input  logic            pop,
    output vbd_pkg::entry_t pop_data,
    output logic            full,
    output logic            empty
);

    vbd_pkg::entry_t                     mem_reg [vbd_pkg::FIFO_DEPTH];
    logic [vbd_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [vbd_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [vbd_pkg::FIFO_CNT_W-1:0]      count_reg, count_next;

    assign full     = (count_reg == vbd_pkg::FIFO_CNT_W'(vbd_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/vbd_front.sv -----
// ----------------------------------------------------------------------------
// vbd_front
// Tracks the raster position of each voxel and classifies it: window
// offsets, cell coordinates, first/last voxel of a cell, end of volume.
// ----------------------------------------------------------------------------
module vbd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  vbd_pkg::cfg_t   cfg,
    input  logic            restart,
    input  logic            accept,
    output logic            push,
    output vbd_pkg::entry_t push_data,
    input  logic signed [vbd_pkg::VOXEL_W-1:0] voxel
);

    localparam int CW = vbd_pkg::COORD_W;
    localparam int OW = vbd_pkg::OFS_W;
    localparam int SW = vbd_pkg::SIZE_W;

    logic [CW-1:0] px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [OW-1:0] ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;
    logic [CW-1:0] cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic [CW-1:0] stx_reg, sty_reg, stz_reg, stx_next, sty_next, stz_next;

    logic [OW-1:0] f_last;
    logic [SW-1:0] f_ext;
    logic          x_end, y_end, z_end;
    logic          x_wrap, y_wrap, z_wrap;
    logic          in_x, in_y, in_z;
    logic          lastc_x, lastc_y, lastc_z;

    assign f_last = OW'(cfg.factor - 1'b1);
    assign f_ext  = SW'(cfg.factor);

    // cell window complete inside the extent: start + f <= size
    assign in_x = ({1'b0, stx_reg} + f_ext) <= cfg.size_x;
    assign in_y = ({1'b0, sty_reg} + f_ext) <= cfg.size_y;
    assign in_z = ({1'b0, stz_reg} + f_ext) <= cfg.size_z;

    // no further whole window fits after this one
    assign lastc_x = ({1'b0, stx_reg} + f_ext + f_ext) > cfg.size_x;
    assign lastc_y = ({1'b0, sty_reg} + f_ext + f_ext) > cfg.size_y;
    assign lastc_z = ({1'b0, stz_reg} + f_ext + f_ext) > cfg.size_z;

    assign x_wrap = ({1'b0, px_reg} + 1'b1) >= cfg.size_x;
    assign y_wrap = ({1'b0, py_reg} + 1'b1) >= cfg.size_y;
    assign z_wrap = ({1'b0, pz_reg} + 1'b1) >= cfg.size_z;

    assign x_end = (ox_reg == f_last);
    assign y_end = (oy_reg == f_last);
    assign z_end = (oz_reg == f_last);

    always_comb
    begin
        push_data.voxel = voxel;
        push_data.idx   = {cy_reg, cz_reg};
        push_data.first = (ox_reg == '0) && (oy_reg == '0) && (oz_reg == '0);
        push_data.emit  = x_end && y_end && z_end;
        push_data.cx    = cx_reg;
        push_data.cy    = cy_reg;
        push_data.cz    = cz_reg;
        push_data.done  = lastc_x && lastc_y && lastc_z;
    end

    // drop voxels outside the whole-window region
    assign push = accept && in_x && in_y && in_z;

    always_comb
    begin
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        ox_next = ox_reg; oy_next = oy_reg; oz_next = oz_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        stx_next = stx_reg; sty_next = sty_reg; stz_next = stz_reg;
        if (restart)
        begin
            px_next = '0; py_next = '0; pz_next = '0;
            ox_next = '0; oy_next = '0; oz_next = '0;
            cx_next = '0; cy_next = '0; cz_next = '0;
            stx_next = '0; sty_next = '0; stz_next = '0;
        end
        else if (accept)
        begin
            if (!z_wrap)
            begin
                pz_next = pz_reg + 1'b1;
                if (z_end)
                begin
                    oz_next  = '0;
                    cz_next  = cz_reg + 1'b1;
                    stz_next = CW'(stz_reg + CW'(cfg.factor));
                end
                else
                begin
                    oz_next = oz_reg + 1'b1;
                end
            end
            else
            begin
                pz_next = '0; oz_next = '0; cz_next = '0; stz_next = '0;
                if (!y_wrap)
                begin
                    py_next = py_reg + 1'b1;
                    if (y_end)
                    begin
                        oy_next  = '0;
                        cy_next  = cy_reg + 1'b1;
                        sty_next = CW'(sty_reg + CW'(cfg.factor));
                    end
                    else
                    begin
                        oy_next = oy_reg + 1'b1;
                    end
                end
                else
                begin
                    py_next = '0; oy_next = '0; cy_next = '0; sty_next = '0;
                    if (!x_wrap)
                    begin
                        px_next = px_reg + 1'b1;
                        if (x_end)
                        begin
                            ox_next  = '0;
                            cx_next  = cx_reg + 1'b1;
                            stx_next = CW'(stx_reg + CW'(cfg.factor));
                        end
                        else
                        begin
                            ox_next = ox_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        px_next = '0; ox_next = '0; cx_next = '0; stx_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            stx_reg <= '0; sty_reg <= '0; stz_reg <= '0;
        end
        else
        begin
            px_reg <= px_next; py_reg <= py_next; pz_reg <= pz_next;
            ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
            cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
            stx_reg <= stx_next; sty_reg <= sty_next; stz_reg <= stz_next;
        end
    end

endmodule

// ----- design/vbd_back.sv -----
// ----------------------------------------------------------------------------
// vbd_back
// Accumulates voxels into the plane sum memory and divides finished cell
// sums by factor cubed through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module vbd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vbd_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  vbd_pkg::entry_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic signed [vbd_pkg::VOXEL_W-1:0] mean_value,
    output logic [vbd_pkg::COORD_W-1:0]        cell_x,
    output logic [vbd_pkg::COORD_W-1:0]        cell_y,
    output logic [vbd_pkg::COORD_W-1:0]        cell_z,
    output logic                               volume_done
);

    localparam int SUMW = vbd_pkg::SUM_W;
    localparam int CW   = vbd_pkg::COORD_W;

    logic signed [SUMW-1:0] sums_mem [vbd_pkg::PLANE_CELLS];

    logic                     adv;
    logic                     s1_valid_reg;
    vbd_pkg::entry_t          s1_reg;
    logic signed [SUMW-1:0]   rd_data_reg;
    logic                     fwd_valid_reg;
    logic [vbd_pkg::IDX_W-1:0] fwd_idx_reg;
    logic signed [SUMW-1:0]   fwd_sum_reg;

    logic signed [SUMW-1:0]   base;
    logic signed [SUMW-1:0]   sum;
    logic [SUMW-1:0]          abs_sum;
    logic                     wr_en;
    vbd_pkg::recip_t          rcp;

    logic                          s2_valid_reg;
    logic [vbd_pkg::MAG_W-1:0]     s2_mag_reg;
    logic                          s2_neg_reg;
    vbd_pkg::recip_t               s2_rcp_reg;
    logic [CW-1:0]                 s2_cx_reg, s2_cy_reg, s2_cz_reg;
    logic                          s2_done_reg;

    logic                          s3_valid_reg;
    logic [vbd_pkg::PROD_W-1:0]    s3_prod_reg;
    logic                          s3_neg_reg;
    logic [vbd_pkg::SHIFT_W-1:0]   s3_shift_reg;
    logic [CW-1:0]                 s3_cx_reg, s3_cy_reg, s3_cz_reg;
    logic                          s3_done_reg;

    logic [vbd_pkg::PROD_W-1:0]    quot_full;
    logic [vbd_pkg::VOXEL_W-1:0]   quot;

    logic                          out_valid_reg;
    logic signed [vbd_pkg::VOXEL_W-1:0] mean_reg;
    logic [CW-1:0]                 cx_out_reg, cy_out_reg, cz_out_reg;
    logic                          done_out_reg;

    // whole pipe moves unless a finished beat is held at the output
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;
    assign wr_en = adv && s1_valid_reg;

    // take the sum still in flight when the previous beat hit the same cell
    assign base = (fwd_valid_reg && (fwd_idx_reg == s1_reg.idx)) ? fwd_sum_reg : rd_data_reg;
    assign sum  = s1_reg.first ? SUMW'(s1_reg.voxel) : base + SUMW'(s1_reg.voxel);
    assign abs_sum = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
    assign rcp  = vbd_pkg::recip_of(cfg.factor);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sums_mem[s1_reg.idx] <= sum;
        end
        if (q_pop)
        begin
            rd_data_reg <= sums_mem[q_data.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg && s1_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= q_data;
            if (s1_valid_reg)
            begin
                fwd_idx_reg <= s1_reg.idx;
                fwd_sum_reg <= sum;
            end
            s2_mag_reg   <= abs_sum[vbd_pkg::MAG_W-1:0];
            s2_neg_reg   <= sum[SUMW-1];
            s2_rcp_reg   <= rcp;
            s2_cx_reg    <= s1_reg.cx;
            s2_cy_reg    <= s1_reg.cy;
            s2_cz_reg    <= s1_reg.cz;
            s2_done_reg  <= s1_reg.done;
            s3_prod_reg  <= vbd_pkg::PROD_W'(s2_mag_reg) * vbd_pkg::PROD_W'(s2_rcp_reg.mult);
            s3_neg_reg   <= s2_neg_reg;
            s3_shift_reg <= s2_rcp_reg.shift;
            s3_cx_reg    <= s2_cx_reg;
            s3_cy_reg    <= s2_cy_reg;
            s3_cz_reg    <= s2_cz_reg;
            s3_done_reg  <= s2_done_reg;
            mean_reg     <= s3_neg_reg ? vbd_pkg::VOXEL_W'(-quot) : quot;
            cx_out_reg   <= s3_cx_reg;
            cy_out_reg   <= s3_cy_reg;
            cz_out_reg   <= s3_cz_reg;
            done_out_reg <= s3_done_reg;
        end
    end

    assign quot_full = s3_prod_reg >> s3_shift_reg;
    assign quot      = quot_full[vbd_pkg::VOXEL_W-1:0];

    assign out_valid   = out_valid_reg;
    assign mean_value  = mean_reg;
    assign cell_x      = cx_out_reg;
    assign cell_y      = cy_out_reg;
    assign cell_z      = cz_out_reg;
    assign volume_done = done_out_reg;

endmodule
